FILE: sv/krq_pkg.sv
// ----------------------------------------------------------------------------
// krq_pkg
// Shared types and constants for the keyed record queue: request modes,
// status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package krq_pkg;

  // Record field widths
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned AGE_W   = 7;
  localparam int unsigned MARKS_W = 14;
  localparam int unsigned REC_W   = KEY_W + AGE_W + MARKS_W;
  localparam int unsigned SLOT_W  = 3;

  // Field limits
  localparam logic [AGE_W-1:0]   AGE_MIN   = 7'd5;
  localparam logic [AGE_W-1:0]   AGE_MAX   = 7'd100;
  localparam logic [MARKS_W-1:0] MARKS_MAX = 14'd10000;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_LIST   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_DUP      = 3'd3,
    ST_ZERO     = 3'd4,
    ST_AGE      = 3'd5,
    ST_MARKS    = 3'd6,
    ST_NOTFOUND = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SRD,
    S_SCMP,
    S_LRD,
    S_LOUT,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_req;   // capture the accepted request
    logic    idx_head;   // walk index <= head
    logic    idx_inc;    // walk index + 1
    logic    rd_en;      // read the entry at the walk index
    logic    emit;       // present a result to the output register
    logic    emit_rec;   // result carries the record just read
    status_t status;
  } krq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_t   mode;
    logic    empty;
    logic    full;
    logic    key_zero;
    logic    key_match;  // read entry key equals request key
    logic    at_tail;    // walk index is at the tail slot
    status_t field_st;   // age/marks check of the request
    logic    out_free;   // output register can take a result this cycle
  } krq_stat_t;

endpackage

FILE: sv/krq_ram.sv
// ----------------------------------------------------------------------------
// krq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module krq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/krq_ctrl.sv
// ----------------------------------------------------------------------------
// krq_ctrl
// Request sequencer: decides each request, walks the stored entries for a
// key search or a listing, and hands results to the output register.
// ----------------------------------------------------------------------------
module krq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  krq_pkg::krq_stat_t stat,
  output krq_pkg::krq_cmd_t  cmd
);
  import krq_pkg::*;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  // State and pending status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    st_nxt       = st_r;
    cmd          = '0;
    cmd.status   = st_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end

      // First checks, before any search
      S_DECIDE: begin
        unique case (stat.mode)
          MODE_INSERT: begin
            if (stat.full) begin
              st_nxt    = ST_FULL;
              state_nxt = S_EMIT;
            end else if (stat.key_zero) begin
              st_nxt    = ST_ZERO;
              state_nxt = S_EMIT;
            end else if (stat.empty) begin
              st_nxt    = stat.field_st;
              state_nxt = S_EMIT;
            end else begin
              cmd.idx_head = 1'b1;
              state_nxt    = S_SRD;
            end
          end
          MODE_UPDATE: begin
            if (stat.empty) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_EMIT;
            end else if (stat.key_zero) begin
              st_nxt    = ST_ZERO;
              state_nxt = S_EMIT;
            end else begin
              cmd.idx_head = 1'b1;
              state_nxt    = S_SRD;
            end
          end
          MODE_REMOVE: begin
            st_nxt    = stat.empty ? ST_EMPTY : ST_OK;
            state_nxt = S_EMIT;
          end
          MODE_LIST: begin
            if (stat.empty) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_EMIT;
            end else begin
              cmd.idx_head = 1'b1;
              state_nxt    = S_LRD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      // Key search: read one entry, then compare
      S_SRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SCMP;
      end

      S_SCMP: begin
        if (stat.key_match) begin
          st_nxt    = (stat.mode == MODE_INSERT) ? ST_DUP : stat.field_st;
          state_nxt = S_EMIT;
        end else if (stat.at_tail) begin
          st_nxt    = (stat.mode == MODE_INSERT) ? stat.field_st : ST_NOTFOUND;
          state_nxt = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRD;
        end
      end

      // Listing: read one entry, then send it
      S_LRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LOUT;
      end

      S_LOUT: begin
        cmd.emit     = 1'b1;
        cmd.emit_rec = 1'b1;
        cmd.status   = ST_OK;
        if (stat.out_free) begin
          if (stat.at_tail) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_LRD;
          end
        end
      end

      // Single result, with the commit done by the datapath
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: sv/krq_dp.sv
// ----------------------------------------------------------------------------
// krq_dp
// Datapath: request register, head/tail pointers, walk index, record RAM,
// field checks and the output register.
// ----------------------------------------------------------------------------
module krq_dp #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [1:0]                        in_mode,
  input  logic [krq_pkg::KEY_W-1:0]         in_key,
  input  logic [krq_pkg::AGE_W-1:0]         in_age,
  input  logic [krq_pkg::MARKS_W-1:0]       in_marks_centi,
  input  krq_pkg::krq_cmd_t                 cmd,
  output krq_pkg::krq_stat_t                stat,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_status,
  output logic [krq_pkg::KEY_W-1:0]         out_rec_key,
  output logic [krq_pkg::AGE_W-1:0]         out_rec_age,
  output logic [krq_pkg::MARKS_W-1:0]       out_rec_marks,
  output logic [krq_pkg::SLOT_W-1:0]        out_slot,
  output logic                              out_last
);
  import krq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

  // Request register
  mode_t              mode_r;
  logic [KEY_W-1:0]   key_r;
  logic [AGE_W-1:0]   age_r;
  logic [MARKS_W-1:0] marks_r;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      mode_r  <= mode_t'(in_mode);
      key_r   <= in_key;
      age_r   <= in_age;
      marks_r <= in_marks_centi;
    end
  end

  // Queue pointers and walk index
  logic [IW-1:0] head_r, tail_r, idx_r;
  logic          empty_r;

  logic [REC_W-1:0] rdata;
  logic [KEY_W-1:0] rd_key;
  logic [AGE_W-1:0] rd_age;
  logic [MARKS_W-1:0] rd_marks;

  assign {rd_key, rd_age, rd_marks} = rdata;

  // Field checks
  status_t field_st;
  always_comb begin
    if (age_r < AGE_MIN || age_r > AGE_MAX) begin
      field_st = ST_AGE;
    end else if (marks_r > MARKS_MAX) begin
      field_st = ST_MARKS;
    end else begin
      field_st = ST_OK;
    end
  end

  logic out_valid_r;
  logic out_free;
  logic fire;
  logic commit;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = cmd.emit && out_free;
  assign commit   = fire && !cmd.emit_rec && (cmd.status == ST_OK);

  // Record write on a committed insert or update
  logic          we;
  logic [IW-1:0] waddr;

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    if (commit && mode_r == MODE_INSERT) begin
      we    = 1'b1;
      waddr = empty_r ? '0 : IW'(tail_r + 1'b1);
    end else if (commit && mode_r == MODE_UPDATE) begin
      we    = 1'b1;
      waddr = idx_r;
    end
  end

  krq_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({key_r, age_r, marks_r}),
    .re    (cmd.rd_en),
    .raddr (idx_r),
    .rdata (rdata)
  );

  // Pointer updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (commit) begin
      case (mode_r)
        MODE_INSERT: begin
          if (empty_r) begin
            head_r  <= '0;
            tail_r  <= '0;
            empty_r <= 1'b0;
          end else begin
            tail_r <= IW'(tail_r + 1'b1);
          end
        end
        MODE_REMOVE: begin
          if (head_r == tail_r) begin
            head_r  <= '0;
            tail_r  <= '0;
            empty_r <= 1'b1;
          end else begin
            head_r <= IW'(head_r + 1'b1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_head) begin
      idx_r <= head_r;
    end else if (cmd.idx_inc) begin
      idx_r <= IW'(idx_r + 1'b1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= cmd.status;
      if (cmd.emit_rec) begin
        out_rec_key   <= rd_key;
        out_rec_age   <= rd_age;
        out_rec_marks <= rd_marks;
        out_slot      <= SLOT_W'(idx_r);
        out_last      <= (idx_r == tail_r);
      end else begin
        out_rec_key   <= '0;
        out_rec_age   <= '0;
        out_rec_marks <= '0;
        out_slot      <= '0;
        out_last      <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;

  // Status to the controller
  always_comb begin
    stat           = '0;
    stat.mode      = mode_r;
    stat.empty     = empty_r;
    stat.full      = !empty_r && (tail_r == LAST_SLOT);
    stat.key_zero  = (key_r == '0);
    stat.key_match = (rd_key == key_r);
    stat.at_tail   = (idx_r == tail_r);
    stat.field_st  = field_st;
    stat.out_free  = out_free;
  end

endmodule

FILE: sv/keyed_record_queue.sv
// ----------------------------------------------------------------------------
// keyed_record_queue
// Linear array queue of keyed records (key, age, marks) with insert, update
// by key, remove head and list all.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_stall   in_mode, in_key, in_age, in_marks_centi
//  out       out_valid / out_stall out_status, out_rec_key, out_rec_age,
//                                  out_rec_marks, out_slot, out_last
//
//  One request at a time. Remove decides and emits without a search. Insert
//  and update compare one entry at a time in the key search (head to tail),
//  set by the single registered read port of the record RAM. List reads and
//  sends one entry at a time; a list of an empty queue gives one result.
//  Records are undefined after reset; pointers, empty flag, controller and
//  out_valid reset, so the block is ready on the first cycle after reset.
//  A stalled output holds its result; the walk waits for the output register.
// ----------------------------------------------------------------------------
module keyed_record_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_mode,
  input  logic [krq_pkg::KEY_W-1:0]    in_key,
  input  logic [krq_pkg::AGE_W-1:0]    in_age,
  input  logic [krq_pkg::MARKS_W-1:0]  in_marks_centi,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_status,
  output logic [krq_pkg::KEY_W-1:0]    out_rec_key,
  output logic [krq_pkg::AGE_W-1:0]    out_rec_age,
  output logic [krq_pkg::MARKS_W-1:0]  out_rec_marks,
  output logic [krq_pkg::SLOT_W-1:0]   out_slot,
  output logic                         out_last
);
  import krq_pkg::*;

  krq_cmd_t  cmd;
  krq_stat_t stat;

  krq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  krq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_age         (in_age),
    .in_marks_centi (in_marks_centi),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_rec_key    (out_rec_key),
    .out_rec_age    (out_rec_age),
    .out_rec_marks  (out_rec_marks),
    .out_slot       (out_slot),
    .out_last       (out_last)
  );

endmodule

FILE: verif/tb_keyed_record_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_record_queue
// Self-checking bench for the keyed record queue. A directed table covers
// the rejection codes, the field extremes, the full-after-remove rule and the
// list walk. A random phase follows with mostly legal requests over a small
// key pool, so that matches, duplicates, updates and drains happen often.
// Every result is checked against a behavioral model or a typed row's status.
// ----------------------------------------------------------------------------
module tb_keyed_record_queue;
  import krq_pkg::*;

  localparam int QDEPTH      = 8;
  localparam int HALF_PERIOD = 6;
  localparam int RAND_ITEMS  = 150;
  localparam int CALM_ITEMS  = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 40;
  localparam int DIR_N       = 27;
  localparam int POOL_N      = 10;

  // One expected or observed result
  typedef struct {
    status_t             st;
    logic [KEY_W-1:0]    key;
    logic [AGE_W-1:0]    age;
    logic [MARKS_W-1:0]  marks;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } rec_result_t;

  // One directed request; typed rows carry their status directly
  typedef struct {
    mode_t               mode;
    logic [KEY_W-1:0]    key;
    logic [AGE_W-1:0]    age;
    logic [MARKS_W-1:0]  marks;
    bit                  typed;
    status_t             st;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_mode;
  logic [KEY_W-1:0]     in_key;
  logic [AGE_W-1:0]     in_age;
  logic [MARKS_W-1:0]   in_marks_centi;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           out_status;
  logic [KEY_W-1:0]     out_rec_key;
  logic [AGE_W-1:0]     out_rec_age;
  logic [MARKS_W-1:0]   out_rec_marks;
  logic [SLOT_W-1:0]    out_slot;
  logic                 out_last;

  // Side info for the request on the bus
  bit                   cur_typed;
  status_t              cur_st;

  // Model state
  logic [KEY_W-1:0]     mdl_keys  [QDEPTH];
  logic [AGE_W-1:0]     mdl_ages  [QDEPTH];
  logic [MARKS_W-1:0]   mdl_marks [QDEPTH];
  int                   mdl_head;
  int                   mdl_tail;
  bit                   mdl_empty;

  rec_result_t          pending_results [$];
  int                   mism_cnt;
  bit                   calm;
  bit                   hold_req;
  int                   idle_cnt;
  dir_row_t             dir_tab [DIR_N];
  logic [KEY_W-1:0]     key_pool [POOL_N];

  keyed_record_queue #(.DEPTH(QDEPTH)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_age         (in_age),
    .in_marks_centi (in_marks_centi),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_rec_key    (out_rec_key),
    .out_rec_age    (out_rec_age),
    .out_rec_marks  (out_rec_marks),
    .out_slot       (out_slot),
    .out_last       (out_last)
  );

  // Clock
  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  // Slot holding the key, or -1
  function automatic int find_slot(input logic [KEY_W-1:0] key);
    int i;
    find_slot = -1;
    if (!mdl_empty) begin
      for (i = mdl_tail; i >= mdl_head; i--)
        if (mdl_keys[i] == key) find_slot = i;
    end
  endfunction

  function automatic status_t field_status(input logic [AGE_W-1:0] age,
                                           input logic [MARKS_W-1:0] marks);
    if (age < AGE_MIN || age > AGE_MAX) field_status = ST_AGE;
    else if (marks > MARKS_MAX)         field_status = ST_MARKS;
    else                                field_status = ST_OK;
  endfunction

  function automatic rec_result_t status_only(input status_t st);
    rec_result_t r;
    r = '{st: st, key: '0, age: '0, marks: '0, slot: '0, last: 1'b1};
    return r;
  endfunction

  // Queue model: applies one request and returns the results it causes
  task automatic apply_request(input mode_t m, input logic [KEY_W-1:0] key,
                               input logic [AGE_W-1:0] age,
                               input logic [MARKS_W-1:0] marks,
                               output int n, output rec_result_t res [QDEPTH]);
    status_t st;
    int      idx;
    int      i;
    n = 1;
    st = ST_OK;
    case (m)
      MODE_INSERT: begin
        if (!mdl_empty && mdl_tail >= QDEPTH - 1) st = ST_FULL;
        else if (key == '0)                       st = ST_ZERO;
        else if (find_slot(key) >= 0)             st = ST_DUP;
        else                                      st = field_status(age, marks);
        if (st == ST_OK) begin
          if (mdl_empty) begin
            mdl_head  = 0;
            mdl_tail  = 0;
            mdl_empty = 1'b0;
          end else begin
            mdl_tail++;
          end
          mdl_keys[mdl_tail]  = key;
          mdl_ages[mdl_tail]  = age;
          mdl_marks[mdl_tail] = marks;
        end
        res[0] = status_only(st);
      end
      MODE_UPDATE: begin
        idx = -1;
        if (mdl_empty)       st = ST_EMPTY;
        else if (key == '0)  st = ST_ZERO;
        else begin
          idx = find_slot(key);
          st = (idx >= 0) ? field_status(age, marks) : ST_NOTFOUND;
        end
        if (st == ST_OK) begin
          mdl_ages[idx]  = age;
          mdl_marks[idx] = marks;
        end
        res[0] = status_only(st);
      end
      MODE_REMOVE: begin
        if (mdl_empty) begin
          st = ST_EMPTY;
        end else begin
          mdl_head++;
          // last record gone: back to slot 0
          if (mdl_head > mdl_tail) begin
            mdl_head  = 0;
            mdl_tail  = 0;
            mdl_empty = 1'b1;
          end
        end
        res[0] = status_only(st);
      end
      default: begin
        if (mdl_empty) begin
          res[0] = status_only(ST_EMPTY);
        end else begin
          n = 0;
          for (i = mdl_head; i <= mdl_tail; i++) begin
            res[n] = '{st: ST_OK, key: mdl_keys[i], age: mdl_ages[i],
                       marks: mdl_marks[i], slot: i[SLOT_W-1:0],
                       last: (i == mdl_tail)};
            n++;
          end
        end
      end
    endcase
  endtask

  // Accepted request: predict and queue the results
  always @(posedge clk) begin
    int          n;
    int          k;
    rec_result_t res [QDEPTH];
    if (rst_n && in_valid && !in_stall) begin
      apply_request(mode_t'(in_mode), in_key, in_age, in_marks_centi, n, res);
      if (cur_typed) pending_results.push_back(status_only(cur_st));
      else for (k = 0; k < n; k++) pending_results.push_back(res[k]);
    end
  end

  // Accepted result: compare with the oldest expectation
  always @(posedge clk) begin
    rec_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (mism_cnt < 10)
          $display("unexpected result: status %0d key %h slot %0d last %0b",
                   out_status, out_rec_key, out_slot, out_last);
        mism_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.st || out_rec_key !== want.key ||
            out_rec_age !== want.age || out_rec_marks !== want.marks ||
            out_slot !== want.slot || out_last !== want.last) begin
          if (mism_cnt < 10)
            $display({"result differs: exp st %0d key %h age %0d marks %0d slot %0d ",
                      "last %0b / got st %0d key %h age %0d marks %0d slot %0d last %0b"},
                     want.st, want.key, want.age, want.marks, want.slot, want.last,
                     out_status, out_rec_key, out_rec_age, out_rec_marks, out_slot,
                     out_last);
          mism_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  initial begin
    idle_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("keyed_record_queue: mismatch");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && rst_n && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request; called right after a falling edge, returns after one
  task automatic send_req(input mode_t m, input logic [KEY_W-1:0] key,
                          input logic [AGE_W-1:0] age,
                          input logic [MARKS_W-1:0] marks,
                          input bit typed, input status_t st);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= m;
    in_key         <= key;
    in_age         <= age;
    in_marks_centi <= marks;
    cur_typed      <= typed;
    cur_st         <= st;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random request: mostly legal fields over a small key pool
  task automatic send_random(input mode_t m);
    logic [KEY_W-1:0]   key;
    logic [AGE_W-1:0]   age;
    logic [MARKS_W-1:0] marks;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 5)       key = '0;
    else if (r < 75) key = key_pool[$urandom_range(0, POOL_N - 1)];
    else             key = $urandom;
    if ($urandom_range(0, 99) < 80) age = AGE_W'($urandom_range(AGE_MIN, AGE_MAX));
    else                            age = AGE_W'($urandom_range(0, 127));
    if ($urandom_range(0, 99) < 80) marks = MARKS_W'($urandom_range(0, MARKS_MAX));
    else                            marks = MARKS_W'($urandom_range(0, 16383));
    send_req(m, key, age, marks, 1'b0, ST_OK);
  endtask

  // Main sequence
  initial begin
    int    r;
    mode_t m;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_INSERT;
    in_key         = '0;
    in_age         = '0;
    in_marks_centi = '0;
    cur_typed      = 1'b0;
    cur_st         = ST_OK;
    calm           = 1'b0;
    hold_req       = 1'b0;
    mism_cnt       = 0;
    mdl_head       = 0;
    mdl_tail       = 0;
    mdl_empty      = 1'b1;
    for (int i = 0; i < QDEPTH; i++) begin
      mdl_keys[i]  = '0;
      mdl_ages[i]  = '0;
      mdl_marks[i] = '0;
    end
    for (int i = 0; i < POOL_N; i++) begin
      key_pool[i] = $urandom;
      if (key_pool[i] == '0) key_pool[i] = 32'd1;
    end

    dir_tab = '{
      // empty queue
      '{MODE_REMOVE, 32'd0, 7'd0, 14'd0, 1'b1, ST_EMPTY},
      '{MODE_LIST,   32'd0, 7'd0, 14'd0, 1'b1, ST_EMPTY},
      '{MODE_UPDATE, 32'd5, 7'd20, 14'd0, 1'b1, ST_EMPTY},
      // insert rejections, field extremes
      '{MODE_INSERT, 32'd0, 7'd20, 14'd0, 1'b1, ST_ZERO},
      '{MODE_INSERT, 32'd1, 7'd4, 14'd0, 1'b1, ST_AGE},
      '{MODE_INSERT, 32'd1, 7'd101, 14'd0, 1'b1, ST_AGE},
      '{MODE_INSERT, 32'd1, 7'd127, 14'd0, 1'b1, ST_AGE},
      '{MODE_INSERT, 32'd1, 7'd5, 14'd10001, 1'b1, ST_MARKS},
      '{MODE_INSERT, 32'd1, 7'd5, 14'd16383, 1'b1, ST_MARKS},
      '{MODE_INSERT, 32'd1, 7'd5, 14'd0, 1'b1, ST_OK},
      '{MODE_INSERT, 32'hFFFF_FFFF, 7'd100, 14'd10000, 1'b1, ST_OK},
      '{MODE_INSERT, 32'd1, 7'd30, 14'd500, 1'b1, ST_DUP},
      // update checks
      '{MODE_UPDATE, 32'd0, 7'd30, 14'd500, 1'b1, ST_ZERO},
      '{MODE_UPDATE, 32'd2, 7'd30, 14'd500, 1'b1, ST_NOTFOUND},
      '{MODE_UPDATE, 32'd1, 7'd0, 14'd500, 1'b1, ST_AGE},
      '{MODE_UPDATE, 32'd1, 7'd50, 14'd16000, 1'b1, ST_MARKS},
      '{MODE_UPDATE, 32'd1, 7'd77, 14'd1234, 1'b1, ST_OK},
      '{MODE_LIST,   32'd0, 7'd0, 14'd0, 1'b0, ST_OK},
      // fill to the last slot
      '{MODE_INSERT, 32'h8000_0003, 7'd10, 14'd100, 1'b0, ST_OK},
      '{MODE_INSERT, 32'h0000_0004, 7'd11, 14'd200, 1'b0, ST_OK},
      '{MODE_INSERT, 32'h5555_5555, 7'd12, 14'd300, 1'b0, ST_OK},
      '{MODE_INSERT, 32'hAAAA_AAAA, 7'd13, 14'd400, 1'b0, ST_OK},
      '{MODE_INSERT, 32'h0000_0007, 7'd14, 14'd9999, 1'b0, ST_OK},
      '{MODE_INSERT, 32'h7FFF_FFFF, 7'd99, 14'd1, 1'b0, ST_OK},
      '{MODE_INSERT, 32'd9, 7'd40, 14'd40, 1'b1, ST_FULL},
      // still full after the head leaves
      '{MODE_REMOVE, 32'd0, 7'd0, 14'd0, 1'b1, ST_OK},
      '{MODE_INSERT, 32'd10, 7'd40, 14'd40, 1'b1, ST_FULL}
    };

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    for (int i = 0; i < DIR_N; i++)
      send_req(dir_tab[i].mode, dir_tab[i].key, dir_tab[i].age, dir_tab[i].marks,
               dir_tab[i].typed, dir_tab[i].st);
    send_req(MODE_LIST, 32'd0, 7'd0, 14'd0, 1'b0, ST_OK);

    // Random phase
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 60) hold_req = 1'b1;
      if (n == 80 || n == 100) begin
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      if (n == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // drain run of removes
        repeat ($urandom_range(1, QDEPTH))
          send_req(MODE_REMOVE, $urandom, AGE_W'($urandom), MARKS_W'($urandom),
                   1'b0, ST_OK);
        continue;
      end
      if (r < 42)      m = MODE_INSERT;
      else if (r < 66) m = MODE_UPDATE;
      else if (r < 84) m = MODE_REMOVE;
      else             m = MODE_LIST;
      send_random(m);
    end
    in_valid <= 1'b0;

    // Drain
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mism_cnt == 0 && pending_results.size() == 0) begin
      $display("keyed_record_queue: match");
    end else begin
      $display("keyed_record_queue: mismatch");
    end
    $finish;
  end

endmodule
